FILE: rtl/core/tkc_pkg.sv
// Package for the top-K count table.
// Field widths, operation codes and the structs used by the cell and the top level.
`timescale 1ns / 1ps

package tkc_pkg;

    localparam int TAG_W   = 32;
    localparam int CNT_W   = 31;
    localparam int LIMIT_W = 6;
    localparam int OP_W    = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [TAG_W-1:0] name_tag;
        logic [CNT_W-1:0] item_count;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0] entry_tag;
        logic [CNT_W-1:0] entry_count;
        logic             entry_valid;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
        logic trim;
    } t_cell_ctrl;

endpackage

FILE: rtl/core/top_k_count_table.sv
// Top level of the top-K count table: control, limit register and the cell chain.
// Depends on tkc_pkg and tkc_cell.
//
// Usage:
//   An operation is a transfer at a clock edge with start high and busy low.
//   Insert and clear give no result and leave busy low; the next operation
//   may follow in the next cycle. Code 3 is ignored.
//   Readout of N held entries: busy stays high until all N have passed the head
//   cell, while the chain rotates one slot per cycle through it. The first result
//   is registered from the head cell once busy is set, then one per cycle,
//   descending by count, last marked on the final one. An empty table gives one
//   invalid result, registered at the transfer itself, with busy staying low.
//   Results are held on o_result for exactly one cycle, flagged by o_strobe;
//   the receiver cannot stall them.
//   The limit register is written by i_cfg_we / i_cfg_data, by the user only
//   while idle, not enforced; a lower limit drops the smallest entries at once.
//   Synchronous reset empties the table and sets the limit to 20.
`timescale 1ns / 1ps

module top_k_count_table
    import tkc_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_strobe,
    output t_out_item          o_result,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

    function automatic logic [OCC_W-1:0] f_cap(input logic [LIMIT_W-1:0] lim);
        logic [OCC_W-1:0] cap;
        if (lim == '0) begin
            cap = OCC_W'(1);
        end else if ({1'b0, lim} > (LIMIT_W+1)'(TABLE_DEPTH)) begin
            cap = OCC_W'(TABLE_DEPTH);
        end else begin
            cap = OCC_W'(lim);
        end
        return cap;
    endfunction

    logic [LIMIT_W-1:0] r_limit;
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic [OCC_W-1:0]   r_left;
    logic               r_busy;
    logic               r_strobe;
    t_out_item          r_out;

    logic [OCC_W-1:0]   w_cap;
    logic [OCC_W-1:0]   w_cap_new;
    logic               w_accept;
    t_cell_ctrl         w_ctrl;
    t_entry             w_new;
    t_entry             w_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_ins;
    logic [TABLE_DEPTH-1:0] w_in_range;
    logic [TABLE_DEPTH-1:0] w_keep;

    assign w_cap     = f_cap(r_limit);
    assign w_cap_new = f_cap(i_cfg_data);
    assign w_accept  = start && !r_busy;

    assign w_new.tag   = i_item.name_tag;
    assign w_new.count = i_item.item_count;

    assign w_ctrl.insert = w_accept && (i_item.operation == OP_INSERT);
    assign w_ctrl.clear  = w_accept && (i_item.operation == OP_CLEAR);
    assign w_ctrl.rotate = r_busy;
    assign w_ctrl.trim   = i_cfg_we;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        assign w_in_range[gi] = OCC_W'(gi) < w_cap;
        assign w_keep[gi]     = OCC_W'(gi) < w_cap_new;

        if (gi == 0) begin : g_head
            tkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_in_range   (w_in_range[gi]),
                .i_keep       (w_keep[gi]),
                .i_prev_entry (w_new),
                .i_prev_valid (1'b0),
                .i_prev_ins   (1'b0),
                .i_next_entry (w_entry[(TABLE_DEPTH > 1) ? 1 : 0]),
                .i_next_valid ((TABLE_DEPTH > 1) ? w_valid[(TABLE_DEPTH > 1) ? 1 : 0] : 1'b0),
                .i_head       (w_entry[0]),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_ins        (w_ins[gi])
            );
        end else if (gi == TABLE_DEPTH - 1) begin : g_tail
            tkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_in_range   (w_in_range[gi]),
                .i_keep       (w_keep[gi]),
                .i_prev_entry (w_entry[gi-1]),
                .i_prev_valid (w_valid[gi-1]),
                .i_prev_ins   (w_ins[gi-1]),
                .i_next_entry (w_entry[0]),
                .i_next_valid (1'b0),
                .i_head       (w_entry[0]),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_ins        (w_ins[gi])
            );
        end else begin : g_mid
            tkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_in_range   (w_in_range[gi]),
                .i_keep       (w_keep[gi]),
                .i_prev_entry (w_entry[gi-1]),
                .i_prev_valid (w_valid[gi-1]),
                .i_prev_ins   (w_ins[gi-1]),
                .i_next_entry (w_entry[gi+1]),
                .i_next_valid (w_valid[gi+1]),
                .i_head       (w_entry[0]),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_ins        (w_ins[gi])
            );
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (i_cfg_we) begin
            n_occ = (r_occ > w_cap_new) ? w_cap_new : r_occ;
        end else if (w_ctrl.clear) begin
            n_occ = '0;
        end else if (w_ctrl.insert && (r_occ < w_cap)) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_occ    <= '0;
            r_busy   <= 1'b0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_busy) begin
                r_strobe <= 1'b1;
                r_left   <= r_left - OCC_W'(1);
                r_busy   <= (r_left != OCC_W'(1));
            end else if (w_accept && (i_item.operation == OP_READ)) begin
                if (r_occ == '0) begin
                    r_strobe <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_left <= r_occ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out.entry_tag   <= w_entry[0].tag;
            r_out.entry_count <= w_entry[0].count;
            r_out.entry_valid <= 1'b1;
            r_out.last        <= (r_left == OCC_W'(1));
        end else begin
            r_out.entry_tag   <= '0;
            r_out.entry_count <= '0;
            r_out.entry_valid <= 1'b0;
            r_out.last        <= 1'b1;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_occ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= w_cap)
        else $error("occupancy above limit");

    a_occ_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("valid bits disagree with occupancy");

    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_strobe)
        else $error("readout cycle without result");

    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.entry_valid) |-> o_result.last)
        else $error("empty readout result not marked last");
`endif

endmodule

FILE: rtl/core/tkc_cell.sv
// One slot of the sorted top-K chain: holds an entry and its valid bit.
// Shifts toward the tail on insert, rotates toward the head on readout. Uses tkc_pkg.
`timescale 1ns / 1ps

module tkc_cell
    import tkc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  logic       i_in_range,
    input  logic       i_keep,
    input  t_entry     i_prev_entry,
    input  logic       i_prev_valid,
    input  logic       i_prev_ins,
    input  t_entry     i_next_entry,
    input  logic       i_next_valid,
    input  t_entry     i_head,
    output t_entry     o_entry,
    output logic       o_valid,
    output logic       o_ins
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;
    logic   w_take_new;
    logic   w_take_prev;

    // New item belongs at or before this slot
    assign o_ins = i_in_range && !(r_valid && (r_entry.count >= i_new.count));

    assign w_take_new  = i_ctrl.insert && o_ins && !i_prev_ins;
    assign w_take_prev = i_ctrl.insert && o_ins && i_prev_ins;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.trim) begin
            n_valid = r_valid && i_keep;
        end else if (w_take_new) begin
            n_entry = i_new;
            n_valid = 1'b1;
        end else if (w_take_prev) begin
            n_entry = i_prev_entry;
            n_valid = i_prev_valid;
        end else if (i_ctrl.rotate && r_valid) begin
            n_entry = i_next_valid ? i_next_entry : i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

FILE: verif/top_k_count_table_checker.sv
// Checker for the top-K count table: watches operation, result and limit transfers,
// keeps its own sorted copy of the table and compares every result in order.
// Depends on tkc_pkg.
`timescale 1ns / 1ps

module top_k_count_table_checker
    import tkc_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  t_in_item           i_item,
    input  logic               o_strobe,
    input  t_out_item          o_result,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 checked_count
);

    t_entry             kept [TABLE_DEPTH];
    int unsigned        kept_n;
    logic [LIMIT_W-1:0] keep_limit;
    t_out_item          sorted_entries_q[$];
    int                 mismatches;
    int                 checked;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        mismatches    = 0;
        checked       = 0;
        kept_n        = 0;
        keep_limit    = LIMIT_RESET;
    end

    function automatic int unsigned keep_cap();
        if (keep_limit == '0) return 1;
        if (keep_limit > TABLE_DEPTH) return TABLE_DEPTH;
        return 32'(keep_limit);
    endfunction

    function automatic void rank_pair(t_in_item it);
        int unsigned cap;
        int unsigned pos;
        int unsigned last_idx;
        int unsigned i;
        cap = keep_cap();
        pos = 0;
        if (kept_n >= cap) begin
            kept_n = cap;
            if (it.item_count <= kept[cap-1].count) return;
            last_idx = cap - 1;
        end else begin
            last_idx = kept_n;
            kept_n++;
        end
        // ties stay behind earlier entries
        while (pos < last_idx && kept[pos].count >= it.item_count) pos++;
        for (i = last_idx; i > pos; i--) kept[i] = kept[i-1];
        kept[pos].tag   = it.name_tag;
        kept[pos].count = it.item_count;
    endfunction

    function automatic void queue_readout();
        t_out_item r;
        int unsigned i;
        if (kept_n == 0) begin
            r = '{entry_tag: '0, entry_count: '0, entry_valid: 1'b0, last: 1'b1};
            sorted_entries_q.push_back(r);
        end else begin
            for (i = 0; i < kept_n; i++) begin
                r.entry_tag   = kept[i].tag;
                r.entry_count = kept[i].count;
                r.entry_valid = 1'b1;
                r.last        = (i + 1 == kept_n);
                sorted_entries_q.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            kept_n     = 0;
            keep_limit = LIMIT_RESET;
            sorted_entries_q.delete();
        end else begin
            if (o_strobe !== 1'b0) begin
                if (sorted_entries_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none actual %h", $time, o_result);
                end else begin
                    want = sorted_entries_q.pop_front();
                    checked++;
                    check_field("entry_tag", want.entry_tag, o_result.entry_tag);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(o_result.entry_count));
                    check_field("entry_valid", 32'(want.entry_valid),
                                32'(o_result.entry_valid));
                    check_field("last", 32'(want.last), 32'(o_result.last));
                end
            end
            if (i_cfg_we) begin
                keep_limit = i_cfg_data;
                if (kept_n > keep_cap()) kept_n = keep_cap();
            end
            if (start && !busy) begin
                case (i_item.operation)
                    OP_INSERT: rank_pair(i_item);
                    OP_READ:   queue_readout();
                    OP_CLEAR:  kept_n = 0;
                    default:   ;
                endcase
            end
        end
        fail_count    <= mismatches;
        pending_count <= sorted_entries_q.size();
        checked_count <= checked;
    end

endmodule

FILE: verif/top_k_count_table_tb.sv
// Testbench top for the top-K count table: clock, reset, operation and limit stimulus.
// Depends on tkc_pkg, top_k_count_table and top_k_count_table_checker.
`timescale 1ns / 1ps

module top_k_count_table_tb;
    import tkc_pkg::*;

    localparam int TABLE_DEPTH = 32;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_item           i_item;
    logic               o_strobe;
    t_out_item          o_result;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;

    int drain_errs;
    int n_insert;
    int n_read;
    int n_clear;
    int n_ignored;
    int n_limit;
    bit idle_on;

    top_k_count_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    top_k_count_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("top_k_count_table_tb: done, errors");
        $finish;
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                        input logic [CNT_W-1:0] cnt);
        t_in_item it;
        it.operation  = op;
        it.name_tag   = tag;
        it.item_count = cnt;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (op)
            OP_INSERT: n_insert++;
            OP_READ:   n_read++;
            OP_CLEAR:  n_clear++;
            default:   n_ignored++;
        endcase
        if (idle_on && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_count != 0) begin
            drain_errs++;
            $display("%0t: results missing: expected %0d more actual 0", $time, pending_count);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_limit++;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return CNT_W'($urandom_range(0, 15));
            6, 7:             return CNT_W'($urandom() >> 1);
            8:                return {CNT_W{1'b1}} - CNT_W'($urandom_range(0, 3));
            default:          return '0;
        endcase
    endfunction

    task automatic send_random(output bit counted);
        int r;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 74) begin
            send(OP_INSERT, $urandom(), pick_count());
        end else if (r < 88) begin
            send(OP_READ, $urandom(), CNT_W'($urandom()));
        end else if (r < 93) begin
            send(OP_CLEAR, $urandom(), CNT_W'($urandom()));
        end else begin
            send(OP_UNUSED, $urandom(), CNT_W'($urandom()));
            counted = 1'b0;
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] lim_plan [8];
        int                 len_plan [8];
        int                 done_items;
        bit                 counted;

        lim_plan = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd7, 6'd3, 6'd17, 6'd32};
        len_plan = '{8, 24, 10, 7, 8, 6, 7, 8};
        drain_errs = 0;
        n_insert   = 0;
        n_read     = 0;
        n_clear    = 0;
        n_ignored  = 0;
        n_limit    = 0;
        idle_on    = 1'b1;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limit, empty readout, extremes, ties, unused code
        send(OP_READ, '0, '0);
        send(OP_INSERT, '0, '0);
        send(OP_INSERT, '1, '1);
        send(OP_INSERT, 32'hA5A5_A5A5, 31'd5);
        send(OP_INSERT, 32'h5A5A_5A5A, 31'd5);
        send(OP_UNUSED, '1, '1);
        send(OP_READ, '0, '0);
        send(OP_CLEAR, '0, '0);
        send(OP_READ, '0, '0);

        // full table: equal to smallest is dropped, greater replaces it
        set_limit(6'd2);
        send(OP_INSERT, 32'd1, 31'd10);
        send(OP_INSERT, 32'd2, 31'd20);
        send(OP_INSERT, 32'd3, 31'd10);
        send(OP_INSERT, 32'd4, 31'd11);
        send(OP_INSERT, 32'd5, 31'd0);
        send(OP_READ, '0, '0);

        // lowering the limit trims the smallest entries
        set_limit(6'd1);
        send(OP_READ, '0, '0);
        send(OP_INSERT, 32'd6, '1);
        send(OP_READ, '0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            set_limit(lim_plan[ph]);
            idle_on    = (ph % 3 != 1) && (ph != 7);
            done_items = 0;
            while (done_items < len_plan[ph]) begin
                send_random(counted);
                if (counted) done_items++;
            end
            send(OP_READ, '0, '0);
        end

        drain();
        $display("Covered %0d inserts, %0d readouts, %0d clears, %0d unused codes",
                 n_insert, n_read, n_clear, n_ignored);
        $display("over %0d limit writes (1 to 63, 0 and trims); %0d results compared",
                 n_limit, checked_count);
        if (fail_count == 0 && drain_errs == 0) begin
            $display("top_k_count_table_tb: done, clean");
        end else begin
            $display("top_k_count_table_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: top_k_count_table.f
rtl/core/tkc_pkg.sv
rtl/core/tkc_cell.sv
rtl/core/top_k_count_table.sv
verif/top_k_count_table_checker.sv
verif/top_k_count_table_tb.sv
